[rtl/rvm_pkg.sv]
// ----------------------------------------------------------------------------
// rvm_pkg
// Shared types, constants and sorting networks of the 5x5 RGB median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rvm_pkg;

	localparam int LINE_WIDTH = 2048;
	localparam int ADDR_W     = $clog2(LINE_WIDTH);
	localparam int CNT_W      = $clog2(LINE_WIDTH + 1);
	localparam int NUM_LINES  = 4;
	localparam int WIN_N      = 25;
	localparam int WIN_LAG    = 4;
	localparam int NUM_CHAN   = 3;

	typedef logic [7:0]                 chan_t;
	typedef logic [23:0]                rgb_t;
	typedef logic [ADDR_W-1:0]          addr_t;
	typedef logic [CNT_W-1:0]           cnt_t;
	typedef logic [1:0]                 phase_t;
	typedef logic [NUM_LINES-1:0]       bank_mask_t;
	typedef logic [NUM_LINES-1:0][23:0] bank_data_t;
	typedef logic [WIN_N-1:0][7:0]      chwin_t;
	typedef logic [WIN_N-1:0][23:0]     rgbwin_t;
	typedef logic [4:0][7:0]            vec5_t;
	typedef logic [3:0][7:0]            vec4_t;
	typedef logic [2:0][7:0]            vec3_t;

	typedef struct packed {
		logic hsync;
		logic vsync;
		logic enable;
	} sync_t;

	function automatic vec5_t cs5(vec5_t v, logic [2:0] i, logic [2:0] j);
		vec5_t r;
		r = v;
		if (v[j] < v[i]) begin
			r[i] = v[j];
			r[j] = v[i];
		end
		return r;
	endfunction

	function automatic vec4_t cs4(vec4_t v, logic [1:0] i, logic [1:0] j);
		vec4_t r;
		r = v;
		if (v[j] < v[i]) begin
			r[i] = v[j];
			r[j] = v[i];
		end
		return r;
	endfunction

	function automatic vec3_t cs3(vec3_t v, logic [1:0] i, logic [1:0] j);
		vec3_t r;
		r = v;
		if (v[j] < v[i]) begin
			r[i] = v[j];
			r[j] = v[i];
		end
		return r;
	endfunction

	function automatic vec5_t net5(vec5_t a);
		vec5_t v;
		v = a;
		v = cs5(v, 3'd0, 3'd4);
		v = cs5(v, 3'd0, 3'd2);
		v = cs5(v, 3'd1, 3'd3);
		v = cs5(v, 3'd2, 3'd4);
		v = cs5(v, 3'd0, 3'd1);
		v = cs5(v, 3'd2, 3'd3);
		v = cs5(v, 3'd1, 3'd4);
		v = cs5(v, 3'd1, 3'd2);
		v = cs5(v, 3'd3, 3'd4);
		return v;
	endfunction

	function automatic vec4_t net4(vec4_t a);
		vec4_t v;
		v = a;
		v = cs4(v, 2'd0, 2'd1);
		v = cs4(v, 2'd2, 2'd3);
		v = cs4(v, 2'd0, 2'd2);
		v = cs4(v, 2'd1, 2'd3);
		v = cs4(v, 2'd1, 2'd2);
		return v;
	endfunction

	function automatic vec3_t net3(vec3_t a);
		vec3_t v;
		v = a;
		v = cs3(v, 2'd1, 2'd2);
		v = cs3(v, 2'd0, 2'd2);
		v = cs3(v, 2'd0, 2'd1);
		return v;
	endfunction

endpackage

`default_nettype wire

[rtl/rvm_line_buf.sv]
// ----------------------------------------------------------------------------
// rvm_line_buf
// Four line stores read together at one column, one write port per store.
// ----------------------------------------------------------------------------
`default_nettype none

module rvm_line_buf (
	input  wire                 clk,
	input  wire                 rd_en,
	input  rvm_pkg::addr_t      rd_addr,
	output rvm_pkg::bank_data_t rd_data,
	input  rvm_pkg::bank_mask_t wr_mask,
	input  rvm_pkg::addr_t      wr_addr,
	input  rvm_pkg::rgb_t       wr_data
);
	import rvm_pkg::*;

	genvar k;
	generate
		for (k = 0; k < NUM_LINES; k++) begin : g_bank
			rgb_t mem [LINE_WIDTH];

			always_ff @(posedge clk) begin
				if (wr_mask[k]) begin
					mem[wr_addr] <= wr_data;
				end
			end

			// same-cycle write to the read column is passed straight on
			always_ff @(posedge clk) begin
				if (rd_en) begin
					if (wr_mask[k] && (wr_addr == rd_addr)) begin
						rd_data[k] <= wr_data;
					end else begin
						rd_data[k] <= mem[rd_addr];
					end
				end
			end
		end
	endgenerate

endmodule

`default_nettype wire

[rtl/rvm_median_lane.sv]
// ----------------------------------------------------------------------------
// rvm_median_lane
// One colour lane: column, row and diagonal sorting networks over a 5x5
// window, four pipeline stages, centre element out.
// ----------------------------------------------------------------------------
`default_nettype none

module rvm_median_lane (
	input  wire            clk,
	input  wire            adv,
	input  rvm_pkg::chwin_t win,
	output rvm_pkg::chan_t  med
);
	import rvm_pkg::*;

	chwin_t cols_d, rows_d, diag_d;
	chwin_t cols_s3, rows_s4, diag_s5;
	chan_t  med_s6;
	vec3_t  d4;

	always_comb begin
		vec5_t v;
		cols_d = win;
		for (int i = 0; i < 5; i++) begin
			for (int k = 0; k < 5; k++) v[k] = win[i + 5 * k];
			v = net5(v);
			for (int k = 0; k < 5; k++) cols_d[i + 5 * k] = v[k];
		end
	end

	always_comb begin
		vec5_t v;
		rows_d = cols_s3;
		for (int i = 0; i < 5; i++) begin
			for (int k = 0; k < 5; k++) v[k] = cols_s3[5 * i + k];
			v = net5(v);
			for (int k = 0; k < 5; k++) rows_d[5 * i + k] = v[k];
		end
	end

	// the three long diagonals share no position
	always_comb begin
		vec4_t a1, a3;
		vec5_t a2;
		diag_d = rows_s4;
		a1 = net4({rows_s4[15], rows_s4[11], rows_s4[7], rows_s4[3]});
		a2 = net5({rows_s4[20], rows_s4[16], rows_s4[12], rows_s4[8], rows_s4[4]});
		a3 = net4({rows_s4[21], rows_s4[17], rows_s4[13], rows_s4[9]});
		diag_d[3]  = a1[0];
		diag_d[7]  = a1[1];
		diag_d[11] = a1[2];
		diag_d[15] = a1[3];
		diag_d[4]  = a2[0];
		diag_d[8]  = a2[1];
		diag_d[12] = a2[2];
		diag_d[16] = a2[3];
		diag_d[20] = a2[4];
		diag_d[9]  = a3[0];
		diag_d[13] = a3[1];
		diag_d[17] = a3[2];
		diag_d[21] = a3[3];
	end

	assign d4 = net3({diag_s5[15], diag_s5[12], diag_s5[9]});

	always_ff @(posedge clk) begin
		if (adv) begin
			cols_s3 <= cols_d;
			rows_s4 <= rows_d;
			diag_s5 <= diag_d;
			med_s6  <= d4[1];
		end
	end

	assign med = med_s6;

endmodule

`default_nettype wire

[rtl/rgb_video_median_5x5.sv]
// ----------------------------------------------------------------------------
// rgb_video_median_5x5
// Approximate 5x5 median filter for an RGB pixel stream, sync passed through.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock and gives one result beat per beat; the
// whole pipeline holds while the result is not taken. The rate is set by
// the single read port of the four line stores, read once per beat. After
// reset a clearing pass zeroes the line stores, one column of all four
// lines per cycle, over all LINE_WIDTH (2048) columns; pix_ready stays low
// until it is done. Three colour lanes run the sorting networks side by
// side and their medians are merged with the sync bits in the output
// stage.
`default_nettype none

module rgb_video_median_5x5 (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          pix_valid,
	output logic         pix_ready,
	input  wire  [7:0]   red_in,
	input  wire  [7:0]   green_in,
	input  wire  [7:0]   blue_in,
	input  wire          hsync_in,
	input  wire          vsync_in,
	input  wire          enable_in,
	output logic         res_valid,
	input  wire          res_ready,
	output logic [7:0]   red_out,
	output logic [7:0]   green_out,
	output logic [7:0]   blue_out,
	output logic         hsync_out,
	output logic         vsync_out,
	output logic         enable_out
);
	import rvm_pkg::*;

	logic       adv, acc;
	logic       clr_q;
	addr_t      clr_addr_q;
	cnt_t       col_q, col0;
	phase_t     ph_q, ph0;
	logic       hs_prev_q;
	logic       rd_ok;

	logic       vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	sync_t      sync_s1, sync_s2, sync_s3, sync_s4, sync_s5, sync_s6;
	rgb_t       pix_s1;
	logic       ok_s1;
	cnt_t       col_s1;
	phase_t     ph_s1;

	bank_data_t rd_data;
	bank_mask_t wr_mask;
	addr_t      wr_addr;
	rgb_t       wr_data;
	logic       wr_line;
	cnt_t       wr_col;

	rgbwin_t    window_q, win_ld, win_s2;
	chan_t      med [NUM_CHAN];

	assign adv       = !vld_s6 || res_ready;
	assign pix_ready = adv && !clr_q;
	assign acc       = pix_valid && pix_ready;

	// position after vsync and hsync edge of this beat
	always_comb begin
		col0 = vsync_in ? '0 : col_q;
		ph0  = vsync_in ? '0 : ph_q;
		if (hsync_in && !hs_prev_q) begin
			col0 = '0;
			ph0  = ph0 + 2'd1;
		end
	end

	assign rd_ok = (col0 < cnt_t'(LINE_WIDTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			ph_q      <= '0;
			hs_prev_q <= 1'b0;
		end else if (acc) begin
			col_q     <= (enable_in && rd_ok) ? col0 + cnt_t'(1) : col0;
			ph_q      <= ph0;
			hs_prev_q <= hsync_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + addr_t'(1);
			if (clr_addr_q == addr_t'(LINE_WIDTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// write back the pixel leaving the first window row
	assign wr_col  = col_s1 - cnt_t'(WIN_LAG);
	assign wr_line = vld_s1 && adv && (col_s1 >= cnt_t'(WIN_LAG));
	assign wr_mask = clr_q ? '1 : (wr_line ? (bank_mask_t'(1) << ph_s1) : '0);
	assign wr_addr = clr_q ? clr_addr_q : wr_col[ADDR_W-1:0];
	assign wr_data = clr_q ? '0 : window_q[4];

	rvm_line_buf u_line_buf (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (col0[ADDR_W-1:0]),
		.rd_data (rd_data),
		.wr_mask (wr_mask),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (acc) begin
				sync_s1 <= '{hsync: hsync_in, vsync: vsync_in, enable: enable_in};
				pix_s1  <= {blue_in, green_in, red_in};
				ok_s1   <= rd_ok;
				col_s1  <= col0;
				ph_s1   <= ph0;
			end
			sync_s2 <= sync_s1;
			sync_s3 <= sync_s2;
			sync_s4 <= sync_s3;
			sync_s5 <= sync_s4;
			sync_s6 <= sync_s5;
			win_s2  <= win_ld;
		end
	end

	// load new pixel and the four stored lines into the window
	always_comb begin
		win_ld = window_q;
		if (sync_s1.enable) begin
			win_ld[0] = pix_s1;
			for (int k = 0; k < NUM_LINES; k++) begin
				win_ld[20 - 5 * k] = ok_s1 ? rd_data[k] : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (vld_s1 && adv) begin
			window_q[0] <= win_ld[0];
			for (int i = 1; i < WIN_N; i++) begin
				window_q[i] <= win_ld[i - 1];
			end
		end
	end

	genvar c;
	generate
		for (c = 0; c < NUM_CHAN; c++) begin : g_lane
			chwin_t lane_win;
			always_comb begin
				for (int i = 0; i < WIN_N; i++) lane_win[i] = win_s2[i][8 * c +: 8];
			end
			rvm_median_lane u_lane (
				.clk (clk),
				.adv (adv),
				.win (lane_win),
				.med (med[c])
			);
		end
	endgenerate

	assign res_valid  = vld_s6;
	assign red_out    = med[0];
	assign green_out  = med[1];
	assign blue_out   = med[2];
	assign hsync_out  = sync_s6.hsync;
	assign vsync_out  = sync_s6.vsync;
	assign enable_out = sync_s6.enable;

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= cnt_t'(LINE_WIDTH))
		else $error("column count past line width");

	a_vsync_phase: assert property (@(posedge clk) disable iff (!arst_n)
		acc && vsync_in && !(hsync_in && !hs_prev_q) |=> ph_q == '0 && col_q <= cnt_t'(1))
		else $error("vsync did not clear position");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !vld_s1 && !wr_line)
		else $error("pipeline active during clearing pass");

	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> vld_s1)
		else $error("transfer lost before stage one");

endmodule

`default_nettype wire

[sim/rgb_video_median_5x5_test.sv]
// ----------------------------------------------------------------------------
// rgb_video_median_5x5_test
// Self-checking bench for the 5x5 RGB approximate median filter: video frames
// with random pixels, blanking and noise beats are pushed through with random
// gaps on both channels and every result beat is compared with a predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_video_median_5x5_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rvm_pkg::*;

	localparam int ITEMS     = 1850;
	localparam int IDLE_MAX  = 5000;
	localparam int TAIL      = 20;

	class median_scoreboard;
		rgb_t  lines[4][LINE_WIDTH];
		rgb_t  win[25];
		int    col;
		bit [1:0] phase;
		bit    hs_prev;
		rgb_t  pix_q[$];
		bit [2:0] sync_q[$];
		int    errors;
		int    checked;

		function void clear();
			foreach (lines[l, a]) lines[l][a] = '0;
			foreach (win[i]) win[i] = '0;
			col = 0;
			phase = 0;
			hs_prev = 0;
			errors = 0;
			checked = 0;
		endfunction

		function void cx(ref chan_t v[5], input int i, input int j);
			chan_t t;
			if (v[j] < v[i]) begin
				t = v[i];
				v[i] = v[j];
				v[j] = t;
			end
		endfunction

		// compare-exchange networks for 5, 4 and 3 entries
		function void sort_at(ref chan_t a[25], input int p[5], input int n);
			chan_t v[5];
			for (int k = 0; k < 5; k++) v[k] = (k < n) ? a[p[k]] : 8'd0;
			case (n)
				5: begin
					cx(v, 0, 4); cx(v, 0, 2); cx(v, 1, 3);
					cx(v, 2, 4); cx(v, 0, 1); cx(v, 2, 3);
					cx(v, 1, 4); cx(v, 1, 2); cx(v, 3, 4);
				end
				4: begin
					cx(v, 0, 1); cx(v, 2, 3); cx(v, 0, 2);
					cx(v, 1, 3); cx(v, 1, 2);
				end
				default: begin
					cx(v, 1, 2); cx(v, 0, 2); cx(v, 0, 1);
				end
			endcase
			for (int k = 0; k < n; k++) a[p[k]] = v[k];
		endfunction

		function chan_t median_of(int sh);
			chan_t a[25];
			int p[5];
			foreach (a[i]) a[i] = chan_t'(win[i] >> sh);
			for (int i = 0; i < 5; i++) begin
				for (int k = 0; k < 5; k++) p[k] = i + 5 * k;
				sort_at(a, p, 5);
			end
			for (int i = 0; i < 5; i++) begin
				for (int k = 0; k < 5; k++) p[k] = 5 * i + k;
				sort_at(a, p, 5);
			end
			p = '{3, 7, 11, 15, 0};   sort_at(a, p, 4);
			p = '{4, 8, 12, 16, 20};  sort_at(a, p, 5);
			p = '{9, 13, 17, 21, 0};  sort_at(a, p, 4);
			p = '{9, 12, 15, 0, 0};   sort_at(a, p, 3);
			return a[12];
		endfunction

		function void note_input(chan_t r, chan_t g, chan_t b, bit hs, bit vs, bit de);
			bit rd_ok;
			if (vs) begin
				col = 0;
				phase = 0;
			end
			if (hs && !hs_prev) begin
				col = 0;
				phase = phase + 2'd1;
			end
			if (de) begin
				rd_ok = col < LINE_WIDTH;
				win[0]  = {b, g, r};
				win[20] = rd_ok ? lines[0][col] : '0;
				win[15] = rd_ok ? lines[1][col] : '0;
				win[10] = rd_ok ? lines[2][col] : '0;
				win[5]  = rd_ok ? lines[3][col] : '0;
			end
			pix_q.push_back({median_of(16), median_of(8), median_of(0)});
			sync_q.push_back({hs, vs, de});
			// pixel four places back goes into the current line
			if (col >= 4 && col - 4 < LINE_WIDTH) lines[phase][col-4] = win[4];
			for (int i = 24; i > 0; i--) win[i] = win[i-1];
			if (de && col < LINE_WIDTH) col++;
			hs_prev = hs;
		endfunction

		task report(string what, int got, int want);
			errors++;
			$display("mismatch at result %0d: %s got %0d expected %0d",
				checked, what, got, want);
		endtask

		task check_result(chan_t r, chan_t g, chan_t b, bit hs, bit vs, bit de);
			rgb_t p;
			bit [2:0] s;
			if (pix_q.size() == 0) begin
				report("unexpected transfer", 1, 0);
				return;
			end
			p = pix_q.pop_front();
			s = sync_q.pop_front();
			if (r !== p[7:0])   report("red", int'(r), int'(p[7:0]));
			if (g !== p[15:8])  report("green", int'(g), int'(p[15:8]));
			if (b !== p[23:16]) report("blue", int'(b), int'(p[23:16]));
			if (hs !== s[2])    report("hsync", int'(hs), int'(s[2]));
			if (vs !== s[1])    report("vsync", int'(vs), int'(s[1]));
			if (de !== s[0])    report("enable", int'(de), int'(s[0]));
			checked++;
		endtask

		function int pending();
			return pix_q.size();
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic pix_valid = 0;
	logic pix_ready;
	logic [7:0] red_in = 0, green_in = 0, blue_in = 0;
	logic hsync_in = 0, vsync_in = 0, enable_in = 0;
	logic res_valid;
	logic res_ready = 0;
	logic [7:0] red_out, green_out, blue_out;
	logic hsync_out, vsync_out, enable_out;

	median_scoreboard sb;
	int sent = 0;
	int idle_cycles = 0;
	int frames = 0;
	bit no_gaps = 0;

	always #6 clk = ~clk;

	rgb_video_median_5x5 i_dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_ready(pix_ready),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.hsync_in(hsync_in), .vsync_in(vsync_in), .enable_in(enable_in),
		.res_valid(res_valid), .res_ready(res_ready),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.hsync_out(hsync_out), .vsync_out(vsync_out), .enable_out(enable_out)
	);

	// transfer monitors and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_valid && pix_ready)
				sb.note_input(red_in, green_in, blue_in, hsync_in, vsync_in, enable_in);
			if (res_valid && res_ready)
				sb.check_result(red_out, green_out, blue_out,
					hsync_out, vsync_out, enable_out);
			if ((pix_valid && pix_ready) || (res_valid && res_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_MAX) begin
				$display("timeout: no transfer for %0d cycles", IDLE_MAX);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver side stalls
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			res_ready <= 1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			n = gap_len();
			if (n > 0) begin
				res_ready <= 0;
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic send(chan_t r, chan_t g, chan_t b, bit hs, bit vs, bit de);
		int n;
		pix_valid <= 1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		hsync_in <= hs;
		vsync_in <= vs;
		enable_in <= de;
		do @(posedge clk); while (!pix_ready);
		sent++;
		n = gap_len();
		if (n > 0) begin
			pix_valid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_pix(bit de);
		send(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom), 0, 0, de);
	endtask

	// blanking with hsync, then a run of pixels with a few holes
	task automatic send_line(int npix);
		repeat ($urandom_range(1, 2))
			send(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom), 1, 0, 0);
		for (int i = 0; i < npix; i++) send_pix($urandom_range(0, 9) != 0);
	endtask

	initial begin
		sb = new();
		sb.clear();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// extremes, vsync with hsync edge, held hsync, pixels without enable
		send(8'hFF, 8'h00, 8'hFF, 1, 1, 0);
		send(8'h00, 8'hFF, 8'h00, 1, 0, 0);
		for (int i = 0; i < 6; i++) send(8'hFF, 8'hFF, 8'hFF, 0, 0, 1);
		send(8'h00, 8'h00, 8'h00, 0, 0, 0);
		send(8'h00, 8'h00, 8'h00, 0, 0, 1);
		send(8'h80, 8'h7F, 8'h01, 0, 1, 1);
		for (int l = 0; l < 2; l++) begin
			send(8'h00, 8'h00, 8'h00, 1, 0, 0);
			for (int i = 0; i < 5; i++) send(8'hFF - 8'(i), 8'(i), 8'h55, 0, 0, 1);
		end
		send(8'h12, 8'h34, 8'h56, 1, 1, 1);

		// one line long enough to saturate the column counter
		no_gaps = 1;
		send_line(0);
		for (int i = 0; i < LINE_WIDTH + 8; i++) send_pix(1);
		no_gaps = 0;

		while (frames == 0 || sent < ITEMS) begin
			send(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom), 0, 1, 0);
			frames++;
			no_gaps = $urandom_range(0, 3) == 0;
			repeat ($urandom_range(4, 8)) begin
				send_line($urandom_range(4, 40));
				if ($urandom_range(0, 9) == 0) send_pix(1'($urandom_range(0, 1)));
				if ($urandom_range(0, 7) == 0)
					send(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom),
						1'($urandom), 1'($urandom), 1'($urandom));
			end
			if (frames == 1) begin
				// hold off until the block has drained
				pix_valid <= 0;
				while (sb.pending() > 0) @(posedge clk);
			end
		end
		pix_valid <= 0;

		while (sb.pending() > 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
		$display("%0d beats sent in %0d frames incl. a saturating line; %0d results checked",
			sent, frames, sb.checked);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
